@@ design/dlpw_pkg.sv @@
// shared types, codes and pair decode for the display list pixel writer
package dlpw_pkg;

	localparam int unsigned STORE_DEPTH = 32;
	localparam int unsigned IDX_W       = 5;
	localparam int unsigned COLOR_W     = 8;
	localparam int unsigned POS_W       = 9;

	typedef enum logic [1:0] {
		OP_COLOR  = 2'd0,
		OP_HEADER = 2'd1,
		OP_GFX    = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic {
		CFG_KANGAROO  = 1'b0,
		CFG_READ_MODE = 1'b1
	} cfg_idx_t;

	// graphics mode = read mode | write mode bit * 4
	typedef enum logic [2:0] {
		MODE_TWO_A   = 3'd0,
		MODE_TWO_B   = 3'd1,
		MODE_ONE_PAL = 3'd2,
		MODE_ONE     = 3'd3,
		MODE_SUB_A   = 3'd4,
		MODE_SUB_B   = 3'd5,
		MODE_SUB_ONE = 3'd6,
		MODE_SUB_HI  = 3'd7
	} mode_t;

	// where a pixel colour comes from
	typedef enum logic [1:0] {
		SRC_BG   = 2'd0,
		SRC_RAM  = 2'd1,
		SRC_ZERO = 2'd2
	} src_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [COLOR_W-1:0] data;
	} wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] lidx;
		logic [IDX_W-1:0] ridx;
		logic             en;
		logic             last;
	} pair_t;

	typedef struct packed {
		logic               vld;
		logic [POS_W-1:0]   x;
		logic [IDX_W-1:0]   lidx;
		logic [IDX_W-1:0]   ridx;
		src_t               lsrc;
		src_t               rsrc;
		logic [COLOR_W-1:0] bg;
		logic               en;
		logic               last;
	} req_t;

	// store entry indexes, enable and last flag for pair k of a graphics byte
	function automatic pair_t pair_decode(input logic [2:0] mode, input logic [2:0] pal,
			input logic [7:0] d, input logic [1:0] k, input logic kang);
		pair_t      p;
		logic [7:0] sh;
		logic [1:0] two;
		logic [1:0] sub;
		logic       hi;
		logic       lo;
		sh  = d << {k, 1'b0};
		two = sh[7:6];
		sub = sh[3:2];
		hi  = sh[7];
		lo  = sh[6];
		p.last = (mode[2]) ? (k == 2'd1) : (k == 2'd3);
		case (mode_t'(mode))
			MODE_TWO_A, MODE_TWO_B: begin
				p.lidx = {pal, two};
				p.ridx = {pal, two};
				p.en   = (two != 2'd0) || kang;
			end
			MODE_ONE_PAL: begin
				p.lidx = {pal[2], 2'b00, hi, pal[1]};
				p.ridx = {pal[2], 2'b00, lo, pal[0]};
				p.en   = (two != 2'd0) || (pal[1:0] != 2'd0) || kang;
			end
			MODE_ONE: begin
				p.lidx = {pal, hi, 1'b0};
				p.ridx = {pal, lo, 1'b0};
				p.en   = (two != 2'd0) || kang;
			end
			MODE_SUB_A, MODE_SUB_B: begin
				p.lidx = {pal[2], sub, two};
				p.ridx = {pal[2], sub, two};
				p.en   = (two != 2'd0) || kang;
			end
			MODE_SUB_ONE: begin
				p.lidx = {pal, hi, sub[1]};
				p.ridx = {pal, lo, sub[0]};
				p.en   = ((two | sub) != 2'd0) || kang;
			end
			default: begin
				p.lidx = {pal[2], sub, hi, 1'b0};
				p.ridx = {pal[2], sub, lo, 1'b0};
				p.en   = (two != 2'd0) || kang;
			end
		endcase
		return p;
	endfunction

endpackage

@@ design/display_list_graphics_pixel_writer_top.sv @@
// top level of the display list pixel writer: issue, colour store, output register
//
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | operation, reg_offset, reg_value, header_*,
//         |           |                       | graphics_byte
// out     | output    | out_valid / out_ready | pair_x, left_color, right_color,
//         |           |                       | write_enable, last_pair
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a graphics byte yields four pairs in the two bit and one bit modes and two in the
// write-mode modes, one pair per cycle while the output is not stalled, set by the
// single pair sequencer
// after issue a pair passes the colour store read, then the output register
// reset clears the store's valid bits, so no clearing pass is needed
// a stalled output freezes the whole pipe, ram read port included
module display_list_graphics_pixel_writer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [4:0] reg_offset,
	input  logic [7:0] reg_value,
	input  logic [2:0] header_palette,
	input  logic       header_write_mode,
	input  logic [7:0] header_position,
	input  logic [7:0] graphics_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [8:0] pair_x,
	output logic [7:0] left_color,
	output logic [7:0] right_color,
	output logic       write_enable,
	output logic       last_pair,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);

	// configuration registers
	logic       kangaroo_q;
	logic [1:0] read_mode_q;

	logic            adv;
	dlpw_pkg::wr_t   wr;
	dlpw_pkg::req_t  req;
	dlpw_pkg::req_t  req_s1;
	logic            vld_s1;
	logic [dlpw_pkg::COLOR_W-1:0] ram_l;
	logic [dlpw_pkg::COLOR_W-1:0] ram_r;

	logic                         out_valid_q;
	logic [dlpw_pkg::POS_W-1:0]   out_x_q;
	logic [dlpw_pkg::COLOR_W-1:0] out_l_q;
	logic [dlpw_pkg::COLOR_W-1:0] out_r_q;
	logic                         out_we_q;
	logic                         out_last_q;

	// pipe moves whenever the output register is free or being drained
	assign adv       = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kangaroo_q  <= 1'b0;
			read_mode_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dlpw_pkg::cfg_idx_t'(cfg_index))
				dlpw_pkg::CFG_KANGAROO:  kangaroo_q  <= cfg_data[0];
				dlpw_pkg::CFG_READ_MODE: read_mode_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dlpw_issue u_issue (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.reg_offset        (reg_offset),
		.reg_value         (reg_value),
		.header_palette    (header_palette),
		.header_write_mode (header_write_mode),
		.header_position   (header_position),
		.graphics_byte     (graphics_byte),
		.kang              (kangaroo_q),
		.read_mode         (read_mode_q),
		.wr                (wr),
		.req               (req)
	);

	// colour store: colours one to three of each palette
	dlpw_ram #(
		.WIDTH (dlpw_pkg::COLOR_W),
		.DEPTH (dlpw_pkg::STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (wr.en),
		.waddr   (wr.addr),
		.wdata   (wr.data),
		.re      (adv),
		.raddr_a (req.lidx),
		.raddr_b (req.ridx),
		.rdata_a (ram_l),
		.rdata_b (ram_r)
	);

	// control travels beside the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
		end
	end

	function automatic logic [dlpw_pkg::COLOR_W-1:0] pick(input dlpw_pkg::src_t src,
			input logic [dlpw_pkg::COLOR_W-1:0] bg, input logic [dlpw_pkg::COLOR_W-1:0] mem,
			input logic en);
		logic [dlpw_pkg::COLOR_W-1:0] c;
		case (src)
			dlpw_pkg::SRC_BG:  c = bg;
			dlpw_pkg::SRC_RAM: c = mem;
			default:           c = '0;
		endcase
		return en ? c : '0;
	endfunction

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q    <= req_s1.x;
			out_l_q    <= pick(req_s1.lsrc, req_s1.bg, ram_l, req_s1.en);
			out_r_q    <= pick(req_s1.rsrc, req_s1.bg, ram_r, req_s1.en);
			out_we_q   <= req_s1.en;
			out_last_q <= req_s1.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pair_x       = out_x_q;
	assign left_color   = out_l_q;
	assign right_color  = out_r_q;
	assign write_enable = out_we_q;
	assign last_pair    = out_last_q;

	// transparent pairs carry no colour
	a_transparent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> left_color == 8'd0 && right_color == 8'd0)
		else $error("transparent pair with nonzero colour");

	// with kangaroo mode on every pair is written
	a_kangaroo_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kangaroo_q |-> write_enable)
		else $error("pair dropped in kangaroo mode");

	// a read in flight reaches the output register when the pipe moves
	a_s1_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv |=> out_valid)
		else $error("pair lost between read and output stage");

endmodule

@@ design/dlpw_ram.sv @@
// generic ram, one write port, two registered read ports
module dlpw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ design/dlpw_issue.sv @@
// input decode, object state and pair sequencer issuing colour store reads
module dlpw_issue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [4:0]                   reg_offset,
	input  logic [7:0]                   reg_value,
	input  logic [2:0]                   header_palette,
	input  logic                         header_write_mode,
	input  logic [7:0]                   header_position,
	input  logic [7:0]                   graphics_byte,
	input  logic                         kang,
	input  logic [1:0]                   read_mode,
	output dlpw_pkg::wr_t                wr,
	output dlpw_pkg::req_t               req
);

	logic                                  busy_q;
	logic [1:0]                            k_q;
	logic [7:0]                            byte_q;
	logic [dlpw_pkg::POS_W-1:0]            pos_q;
	logic [2:0]                            pal_q;
	logic                                  wmode_q;
	logic [dlpw_pkg::COLOR_W-1:0]          bg_q;
	logic [dlpw_pkg::STORE_DEPTH-1:0]      valid_q;

	logic          accept;
	logic          issue;
	logic [7:0]    cur_byte;
	logic [1:0]    cur_k;
	dlpw_pkg::pair_t pair;

	assign in_ready = adv && !busy_q;
	assign accept   = in_valid && in_ready;
	assign cur_byte = busy_q ? byte_q : graphics_byte;
	assign cur_k    = busy_q ? k_q : 2'd0;
	// first pair goes out in the cycle the byte is taken
	assign issue    = busy_q ? adv : (accept && (dlpw_pkg::op_t'(operation) == dlpw_pkg::OP_GFX));
	assign pair     = dlpw_pkg::pair_decode({wmode_q, read_mode}, pal_q, cur_byte, cur_k, kang);

	always_comb begin
		wr.en   = accept && (dlpw_pkg::op_t'(operation) == dlpw_pkg::OP_COLOR)
			&& (reg_offset[1:0] != 2'd0);
		wr.addr = reg_offset;
		wr.data = reg_value;

		req.vld  = issue;
		req.x    = pos_q;
		req.lidx = pair.lidx;
		req.ridx = pair.ridx;
		req.bg   = bg_q;
		req.en   = pair.en;
		req.last = pair.last;
		// colour zero of every palette is the shared background
		if (pair.lidx[1:0] == 2'd0) begin
			req.lsrc = dlpw_pkg::SRC_BG;
		end else if (valid_q[pair.lidx]) begin
			req.lsrc = dlpw_pkg::SRC_RAM;
		end else begin
			req.lsrc = dlpw_pkg::SRC_ZERO;
		end
		if (pair.ridx[1:0] == 2'd0) begin
			req.rsrc = dlpw_pkg::SRC_BG;
		end else if (valid_q[pair.ridx]) begin
			req.rsrc = dlpw_pkg::SRC_RAM;
		end else begin
			req.rsrc = dlpw_pkg::SRC_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= 2'd0;
			byte_q  <= 8'd0;
			pos_q   <= '0;
			pal_q   <= 3'd0;
			wmode_q <= 1'b0;
			bg_q    <= '0;
			valid_q <= '0;
		end else begin
			if (accept) begin
				unique case (dlpw_pkg::op_t'(operation))
					dlpw_pkg::OP_COLOR: begin
						if (reg_offset == 5'd0) begin
							bg_q <= reg_value;
						end else if (reg_offset[1:0] != 2'd0) begin
							valid_q[reg_offset] <= 1'b1;
						end
					end
					dlpw_pkg::OP_HEADER: begin
						pal_q   <= header_palette;
						wmode_q <= header_write_mode;
						pos_q   <= {header_position, 1'b0};
					end
					dlpw_pkg::OP_GFX: begin
						byte_q <= graphics_byte;
					end
					default: begin
					end
				endcase
			end
			if (issue) begin
				pos_q  <= pos_q + dlpw_pkg::POS_W'(2);
				busy_q <= !pair.last;
				k_q    <= cur_k + 2'd1;
			end
		end
	end

endmodule
